@@ rtl/assert_macros.svh @@
// Assertion macros shared by the escape decoder RTL.
// Simulation builds get the checks; synthesis builds get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ESD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ESD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ESD_ASSERT(lbl, clk, rst_n, prop, msg)
`define ESD_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

@@ rtl/esd_pkg.sv @@
// Package for the escape sequence decoder: decode modes, result pair type,
// queue sizing and the simple escape table. No dependencies.
package esd_pkg;

    localparam logic [7:0] C_BACKSLASH = 8'h5C;

    localparam int C_QDEPTH = 4;
    localparam int C_QPTR_W = $clog2(C_QDEPTH);
    localparam int C_QCNT_W = $clog2(C_QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_NORMAL    = 2'd0,
        MODE_ESCAPE    = 2'd1,
        MODE_OCTAL_ONE = 2'd2,
        MODE_OCTAL_TWO = 2'd3
    } t_mode;

    typedef struct packed {
        logic [1:0] count;
        logic [7:0] data0;
        logic       last0;
        logic [7:0] data1;
        logic       last1;
    } t_res;

    typedef struct packed {
        logic       hit;
        logic [7:0] val;
    } t_esc;

    function automatic t_esc f_simple_escape(input logic [7:0] b);
        t_esc r;
        r.hit = 1'b1;
        unique case (b)
            8'h22:   r.val = 8'h22;
            8'h61:   r.val = 8'h07;
            8'h62:   r.val = 8'h08;
            8'h66:   r.val = 8'h0C;
            8'h6E:   r.val = 8'h0A;
            8'h72:   r.val = 8'h0D;
            8'h74:   r.val = 8'h09;
            8'h76:   r.val = 8'h0B;
            8'h5C:   r.val = 8'h5C;
            default: begin
                r.hit = 1'b0;
                r.val = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic logic f_is_octal(input logic [7:0] b);
        return b[7:3] == 5'b00110;
    endfunction

endpackage

@@ rtl/c_esd_decode.sv @@
// Escape decode state machine: mode and octal accumulator registers, and the
// zero, one or two result bytes for each accepted request. Uses esd_pkg.
`include "assert_macros.svh"

module c_esd_decode (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    output esd_pkg::t_res o_res
);

    esd_pkg::t_mode r_mode, n_mode;
    logic [7:0]     r_octal, n_octal;
    esd_pkg::t_esc  esc;
    logic           is_oct;
    logic           is_bs;
    logic [7:0]     oct_acc;

    assign esc     = esd_pkg::f_simple_escape(i_in_byte);
    assign is_oct  = esd_pkg::f_is_octal(i_in_byte);
    assign is_bs   = (i_in_byte == esd_pkg::C_BACKSLASH);
    assign oct_acc = {r_octal[4:0], i_in_byte[2:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= esd_pkg::MODE_NORMAL;
            r_octal <= 8'h00;
        end else if (i_accept) begin
            r_mode  <= n_mode;
            r_octal <= n_octal;
        end
    end

    always_comb begin
        n_mode  = esd_pkg::MODE_NORMAL;
        n_octal = 8'h00;
        unique case (r_mode)
            esd_pkg::MODE_NORMAL: begin
                if (is_bs && !i_in_last) begin
                    n_mode = esd_pkg::MODE_ESCAPE;
                end
            end
            esd_pkg::MODE_ESCAPE: begin
                if (!esc.hit && is_oct && !i_in_last) begin
                    n_mode  = esd_pkg::MODE_OCTAL_ONE;
                    n_octal = {5'b00000, i_in_byte[2:0]};
                end
            end
            esd_pkg::MODE_OCTAL_ONE,
            esd_pkg::MODE_OCTAL_TWO: begin
                if (is_oct) begin
                    if (!i_in_last && r_mode == esd_pkg::MODE_OCTAL_ONE) begin
                        n_mode  = esd_pkg::MODE_OCTAL_TWO;
                        n_octal = oct_acc;
                    end
                end else if (is_bs && !i_in_last) begin
                    n_mode = esd_pkg::MODE_ESCAPE;
                end
            end
            default: begin
                n_mode = esd_pkg::MODE_NORMAL;
            end
        endcase
    end

    always_comb begin
        o_res = '0;
        unique case (r_mode)
            esd_pkg::MODE_NORMAL: begin
                if (is_bs) begin
                    if (i_in_last) begin
                        o_res.count = 2'd1;
                        o_res.data0 = esd_pkg::C_BACKSLASH;
                        o_res.last0 = 1'b1;
                    end
                end else begin
                    o_res.count = 2'd1;
                    o_res.data0 = i_in_byte;
                    o_res.last0 = i_in_last;
                end
            end
            esd_pkg::MODE_ESCAPE: begin
                if (esc.hit) begin
                    o_res.count = 2'd1;
                    o_res.data0 = esc.val;
                    o_res.last0 = i_in_last;
                end else if (is_oct) begin
                    if (i_in_last) begin
                        o_res.count = 2'd1;
                        o_res.data0 = {5'b00000, i_in_byte[2:0]};
                        o_res.last0 = 1'b1;
                    end
                end else begin
                    o_res.count = 2'd2;
                    o_res.data0 = esd_pkg::C_BACKSLASH;
                    o_res.last0 = 1'b0;
                    o_res.data1 = i_in_byte;
                    o_res.last1 = i_in_last;
                end
            end
            esd_pkg::MODE_OCTAL_ONE,
            esd_pkg::MODE_OCTAL_TWO: begin
                if (is_oct) begin
                    if (i_in_last || r_mode == esd_pkg::MODE_OCTAL_TWO) begin
                        o_res.count = 2'd1;
                        o_res.data0 = oct_acc;
                        o_res.last0 = i_in_last;
                    end
                end else begin
                    o_res.data0 = r_octal;
                    o_res.last0 = 1'b0;
                    if (is_bs) begin
                        if (i_in_last) begin
                            o_res.count = 2'd2;
                            o_res.data1 = esd_pkg::C_BACKSLASH;
                            o_res.last1 = 1'b1;
                        end else begin
                            o_res.count = 2'd1;
                        end
                    end else begin
                        o_res.count = 2'd2;
                        o_res.data1 = i_in_byte;
                        o_res.last1 = i_in_last;
                    end
                end
            end
            default: begin
                o_res = '0;
            end
        endcase
        if (!i_accept) begin
            o_res.count = 2'd0;
        end
    end

    // The accumulator is only meaningful while an octal run is open.
    `ESD_ASSERT(a_octal_clear_in_normal, i_clk, i_rst_n,
        (r_mode == esd_pkg::MODE_NORMAL || r_mode == esd_pkg::MODE_ESCAPE) |-> (r_octal == 8'h00),
        "octal accumulator not clear outside an octal run")
    `ESD_ASSERT(a_last_ends_string, i_clk, i_rst_n,
        (i_accept && i_in_last) |=> (r_mode == esd_pkg::MODE_NORMAL),
        "decoder left an escape open after the last byte")

endmodule

@@ rtl/c_esd_outq.sv @@
// Result queue of C_QDEPTH entries: takes up to two bytes per cycle from the
// decoder; hands one byte per cycle out while i_ready is high. Uses esd_pkg.
`include "assert_macros.svh"

module c_esd_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esd_pkg::t_res i_res,
    output logic          o_room,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_out_byte,
    output logic          o_out_last
);

    logic [7:0]                     r_qbyte [esd_pkg::C_QDEPTH];
    logic                           r_qlast [esd_pkg::C_QDEPTH];
    logic [esd_pkg::C_QPTR_W-1:0]   r_wptr, n_wptr;
    logic [esd_pkg::C_QPTR_W-1:0]   r_rptr, n_rptr;
    logic [esd_pkg::C_QCNT_W-1:0]   r_count, n_count;
    logic [esd_pkg::C_QPTR_W-1:0]   wptr_next;
    logic                           pop;

    assign o_valid    = (r_count != '0);
    assign o_room     = (r_count <= esd_pkg::C_QCNT_W'(esd_pkg::C_QDEPTH - 2));
    assign pop        = o_valid && i_ready;
    assign o_out_byte = r_qbyte[r_rptr];
    assign o_out_last = r_qlast[r_rptr];
    assign wptr_next  = r_wptr + esd_pkg::C_QPTR_W'(1);

    always_comb begin
        n_wptr  = r_wptr + esd_pkg::C_QPTR_W'(i_res.count);
        n_rptr  = pop ? (r_rptr + esd_pkg::C_QPTR_W'(1)) : r_rptr;
        n_count = r_count + esd_pkg::C_QCNT_W'(i_res.count)
                - esd_pkg::C_QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.count != 2'd0) begin
            r_qbyte[r_wptr] <= i_res.data0;
            r_qlast[r_wptr] <= i_res.last0;
        end
        if (i_res.count == 2'd2) begin
            r_qbyte[wptr_next] <= i_res.data1;
            r_qlast[wptr_next] <= i_res.last1;
        end
    end

    `ESD_ASSERT(a_no_overflow, i_clk, i_rst_n,
        r_count <= esd_pkg::C_QCNT_W'(esd_pkg::C_QDEPTH),
        "result queue overflow")
    `ESD_ASSERT(a_push_needs_room, i_clk, i_rst_n,
        (i_res.count != 2'd0) |-> o_room,
        "results pushed without room in the queue")

endmodule

@@ rtl/c_escape_sequence_decoder.sv @@
// Top level of the escape sequence decoder: request handshakes around the
// decode state machine and the result queue. Uses esd_pkg, c_esd_decode, c_esd_outq.
//
// Usage: raw string bytes enter on i_in_byte with i_in_last marking the final
// byte of a string; a request is taken when i_valid and o_ready are both high.
// Decoded bytes leave on o_out_byte and o_out_last under o_valid and i_ready.
// Each request is decoded in the cycle it is taken and its zero, one or two
// result bytes are registered into a four-entry queue, from which the outputs
// are driven. The block takes one request per cycle while the queue holds at
// most two bytes; the output side moves one byte per cycle while i_ready is
// high, so a string of ordinary bytes then streams at one byte per cycle.
// When the receiver stalls, the queue fills and o_ready falls until space
// returns; o_ready depends only on the queue fill. Reset empties the queue and
// returns the decoder to plain mode with no escape pending.

module c_escape_sequence_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_byte,
    output logic       o_out_last
);

    esd_pkg::t_res res;
    logic          accept;

    assign accept = i_valid && o_ready;

    c_esd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_in_byte (i_in_byte),
        .i_in_last (i_in_last),
        .o_res     (res)
    );

    c_esd_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_res      (res),
        .o_room     (o_ready),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

endmodule

@@ sim/tb_top.sv @@
// Self-checking testbench for c_escape_sequence_decoder: escaped strings go in,
// decoded bytes are checked against a behavioral decoder in a scoreboard class.
// Depends on esd_pkg and the decoder RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SEVEN = 8'h37;
    localparam logic [7:0] ESC_LETTERS [9] = '{"\"", "a", "b", "f", "n", "r", "t", "v", "\\"};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_decoded;

    function automatic bit is_octal_digit(input logic [7:0] b);
        return b >= CH_ZERO && b <= CH_SEVEN;
    endfunction

    function automatic bit escape_value(input logic [7:0] b, output logic [7:0] v);
        bit hit;
        hit = 1'b1;
        case (b)
            "\"":    v = 8'h22;
            "a":     v = 8'h07;
            "b":     v = 8'h08;
            "f":     v = 8'h0C;
            "n":     v = 8'h0A;
            "r":     v = 8'h0D;
            "t":     v = 8'h09;
            "v":     v = 8'h0B;
            "\\":    v = esd_pkg::C_BACKSLASH;
            default: begin
                hit = 1'b0;
                v = 8'h00;
            end
        endcase
        return hit;
    endfunction

    class escape_scoreboard;
        esd_pkg::t_mode mode;
        logic [7:0]     octal_acc;
        t_decoded       decoded_q[$];
        int unsigned    failures;

        function new();
            mode = esd_pkg::MODE_NORMAL;
            octal_acc = 8'h00;
            failures = 0;
        endfunction

        function void push_decoded(input logic [7:0] b, input logic l);
            decoded_q.push_back('{data: b, last: l});
        endfunction

        function void take_plain(input logic [7:0] b, input logic l);
            if (b == esd_pkg::C_BACKSLASH && !l) begin
                mode = esd_pkg::MODE_ESCAPE;
            end else begin
                push_decoded(b, l);
                mode = esd_pkg::MODE_NORMAL;
            end
        endfunction

        function void note_request(input logic [7:0] b, input logic l);
            logic [7:0] v;
            case (mode)
                esd_pkg::MODE_NORMAL: begin
                    take_plain(b, l);
                end
                esd_pkg::MODE_ESCAPE: begin
                    if (escape_value(b, v)) begin
                        push_decoded(v, l);
                        mode = esd_pkg::MODE_NORMAL;
                    end else if (is_octal_digit(b)) begin
                        octal_acc = b - CH_ZERO;
                        if (l) begin
                            push_decoded(octal_acc, 1'b1);
                            mode = esd_pkg::MODE_NORMAL;
                        end else begin
                            mode = esd_pkg::MODE_OCTAL_ONE;
                        end
                    end else begin
                        push_decoded(esd_pkg::C_BACKSLASH, 1'b0);
                        push_decoded(b, l);
                        mode = esd_pkg::MODE_NORMAL;
                    end
                end
                default: begin
                    if (is_octal_digit(b)) begin
                        octal_acc = {octal_acc[4:0], 3'b000} + (b - CH_ZERO);
                        if (l || mode == esd_pkg::MODE_OCTAL_TWO) begin
                            push_decoded(octal_acc, l);
                            mode = esd_pkg::MODE_NORMAL;
                        end else begin
                            mode = esd_pkg::MODE_OCTAL_TWO;
                        end
                    end else begin
                        push_decoded(octal_acc, 1'b0);
                        take_plain(b, l);
                    end
                end
            endcase
            if (mode == esd_pkg::MODE_NORMAL) begin
                octal_acc = 8'h00;
            end
        endfunction

        function void check_result(input logic [7:0] b, input logic l);
            t_decoded exp_item;
            if (decoded_q.size() == 0) begin
                $display("%0t: unexpected byte, expected none, actual %02h last %0b",
                         $realtime, b, l);
                failures++;
                return;
            end
            exp_item = decoded_q.pop_front();
            if (b !== exp_item.data) begin
                $display("%0t: out_byte expected %02h actual %02h", $realtime, exp_item.data, b);
                failures++;
            end
            if (l !== exp_item.last) begin
                $display("%0t: out_last expected %0b actual %0b", $realtime, exp_item.last, l);
                failures++;
            end
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    logic [7:0] i_in_byte;
    logic       i_in_last;
    logic       o_valid;
    logic       i_ready;
    logic [7:0] o_out_byte;
    logic       o_out_last;

    escape_scoreboard sb;
    int unsigned      idle_pct;
    int unsigned      stall_pct;
    int unsigned      bytes_sent;
    logic [7:0]       text_q[$];

    c_escape_sequence_decoder DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_in_byte  (i_in_byte),
        .i_in_last  (i_in_last),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_out_byte (o_out_byte),
        .o_out_last (o_out_last)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready) begin
                sb.note_request(i_in_byte, i_in_last);
            end
            if (o_valid && i_ready) begin
                sb.check_result(o_out_byte, o_out_last);
            end
        end
    end

    task automatic send_request(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= l;
        do @(posedge i_clk); while (!o_ready);
        bytes_sent++;
    endtask

    task automatic send_text_q();
        foreach (text_q[i]) begin
            send_request(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            text_q.push_back(s[i]);
        end
        send_text_q();
    endtask

    task automatic append_token();
        logic [7:0] b;
        logic [7:0] v;
        int         digits;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
                do b = 8'($urandom_range(0, 255)); while (b == esd_pkg::C_BACKSLASH);
                text_q.push_back(b);
            end
            4, 5: begin
                text_q.push_back(esd_pkg::C_BACKSLASH);
                text_q.push_back(ESC_LETTERS[$urandom_range(0, 8)]);
            end
            6, 7: begin
                text_q.push_back(esd_pkg::C_BACKSLASH);
                digits = $urandom_range(1, 3);
                repeat (digits) text_q.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            end
            8: begin
                do b = 8'($urandom_range(0, 255));
                while (escape_value(b, v) || is_octal_digit(b));
                text_q.push_back(esd_pkg::C_BACKSLASH);
                text_q.push_back(b);
            end
            default: begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic run_phase(input int unsigned idle, input int unsigned stall,
                             input int unsigned count);
        int unsigned target;
        int          tokens;
        target = bytes_sent + count;
        idle_pct = idle;
        stall_pct = stall;
        while (bytes_sent < target) begin
            if ($urandom_range(0, 99) < 15) begin
                repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            end else begin
                tokens = $urandom_range(1, 6);
                repeat (tokens) append_token();
                if ($urandom_range(0, 9) == 0) begin
                    text_q.push_back(esd_pkg::C_BACKSLASH);
                end
            end
            send_text_q();
        end
    endtask

    initial begin
        sb = new();
        idle_pct = 0;
        stall_pct = 0;
        bytes_sent = 0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_in_byte <= 8'h00;
        i_in_last <= 1'b0;
        i_ready   <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b1);
        send_text("\\n\\\\\\\"");
        send_text("\\777");
        send_text("\\12\\tq");
        send_text("\\q\\5");
        send_text("\\");
        send_text("\\3x");

        run_phase(0, 0, 375);
        run_phase(63, 0, 375);
        run_phase(0, 63, 375);
        run_phase(11, 11, 375);
        i_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #400_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/esd_pkg.sv
rtl/c_esd_decode.sv
rtl/c_esd_outq.sv
rtl/c_escape_sequence_decoder.sv
sim/tb_top.sv
